FILE: hw/rtl/dsms_pkg.sv
// dsms_pkg: shared constants and the compare network for the diagonal
// second-minimum stencil; no dependencies

package dsms_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_W         = 10;
  localparam int MAX_SIZE_DEF  = 512;
  localparam int GRID_SIZE_RST = 500;

  typedef logic [DATA_W-1:0] data_t;

  // second-smallest of four values, two sorted pairs then a merge
  function automatic data_t second_min(input data_t a, input data_t b,
                                       input data_t c, input data_t d);
    data_t lo1;
    data_t hi1;
    data_t lo2;
    data_t hi2;
    data_t res;
    lo1 = (a < b) ? a : b;
    hi1 = (a < b) ? b : a;
    lo2 = (c < d) ? c : d;
    hi2 = (c < d) ? d : c;
    if (lo1 < lo2) begin
      res = (hi1 < lo2) ? hi1 : lo2;
    end else begin
      res = (lo1 < hi2) ? lo1 : hi2;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/diagonal_second_min_stencil.sv
// diagonal_second_min_stencil: top level, line memory, window and output stage
// depends on dsms_pkg

// Takes one grid sample per clock cycle in raster order and returns one
// updated cell per cycle; nothing limits the rate except backpressure on the
// result channel, since the two previous rows live in a single line memory
// (one entry per column) that is read one column ahead and written once per
// item. A cell's result appears grid_size+1 items after the cell itself and
// is held in the output register, so grid_size+1 flush items must follow
// each grid; the item that emits last restarts the grid. Interior cells
// get the second-smallest diagonal neighbour added with saturation, border
// cells pass through. grid_size writes below 3 act as 3, above MaxSize as
// MaxSize, and each write restarts the grid; write it only while idle.
module diagonal_second_min_stencil
  import dsms_pkg::*;
#(
  parameter int MaxSize = MAX_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_grid_size,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_sample,
  input  logic              in_flush,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value,
  output logic              out_last
);

  localparam int AW = $clog2(MaxSize);
  localparam int RW = $clog2(MaxSize + 2);
  localparam int SIZE_RST = (GRID_SIZE_RST < MaxSize) ? GRID_SIZE_RST : MaxSize;

  typedef logic [AW-1:0] col_t;
  typedef logic [RW-1:0] row_t;

  // grid size and positions
  row_t  size_r, size_nxt;
  row_t  in_row_r, in_row_nxt;
  col_t  in_col_r, in_col_nxt;
  row_t  out_row_r, out_row_nxt;
  col_t  out_col_r, out_col_nxt;

  // diagonal window
  data_t win0_r, win1_r, win2_r, win3_r, win4_r;

  // line memory: upper half two rows back, lower half one row back
  logic [2*DATA_W-1:0] line_mem [MaxSize];
  logic [2*DATA_W-1:0] rd_data_r;

  // output stage
  logic  out_valid_r, out_valid_nxt;
  data_t out_value_r, out_value_nxt;
  logic  out_last_r, out_last_nxt;

  logic  cfg_wr, in_acc, sample_phase, ignore, step, emit, interior, last_cell;
  logic  step_last;
  data_t v, topc, midc, smin;
  logic [DATA_W:0] sum;
  logic [31:0] cfg_ext;
  row_t  size_m1;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  assign topc    = rd_data_r[2*DATA_W-1:DATA_W];
  assign midc    = rd_data_r[DATA_W-1:0];
  assign size_m1 = size_r - row_t'(1);

  // item classification
  assign sample_phase = in_row_r < size_r;
  assign ignore       = sample_phase && in_flush;
  assign step         = in_acc && !ignore;
  assign v            = sample_phase ? in_sample : '0;
  assign emit         = (in_row_r > row_t'(1)) || ((in_row_r == row_t'(1)) && (in_col_r != '0));
  assign last_cell    = (out_row_r == size_m1) && (row_t'(out_col_r) == size_m1);
  assign interior     = (out_row_r != '0) && (out_row_r != size_m1) &&
                        (out_col_r != '0) && (row_t'(out_col_r) != size_m1);
  assign step_last    = step && emit && last_cell;

  // compare network and saturating add
  assign smin = second_min(win1_r, topc, win4_r, v);
  assign sum  = {1'b0, win2_r} + {1'b0, smin};

  // configuration size, zero-extended to 32 bits
  assign cfg_ext = {{(32-CFG_W){1'b0}}, cfg_grid_size};

  // position update
  always_comb begin
    size_nxt    = size_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (cfg_wr) begin
      if (cfg_ext < 32'd3) begin
        size_nxt = row_t'(3);
      end else if (cfg_ext > 32'(MaxSize)) begin
        size_nxt = row_t'(MaxSize);
      end else begin
        size_nxt = row_t'(cfg_ext);
      end
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (step) begin
      if (step_last) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else begin
        if (row_t'(in_col_r) == size_m1) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + row_t'(1);
        end else begin
          in_col_nxt = in_col_r + col_t'(1);
        end
        if (emit) begin
          if (row_t'(out_col_r) == size_m1) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + row_t'(1);
          end else begin
            out_col_nxt = out_col_r + col_t'(1);
          end
        end
      end
    end
  end

  // result register next values
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = last_cell;
      if (interior) begin
        out_value_nxt = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
      end else begin
        out_value_nxt = win2_r;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= row_t'(SIZE_RST);
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: window and result
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    if (step) begin
      win1_r <= win0_r;
      win0_r <= topc;
      win2_r <= midc;
      win4_r <= win3_r;
      win3_r <= v;
    end
  end

  // line memory, read at the column of the next item
  always_ff @(posedge clk) begin
    if (step) begin
      line_mem[in_col_r] <= {midc, v};
    end
    rd_data_r <= line_mem[in_col_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // the column counter stays inside the grid
  assert property (@(posedge clk) disable iff (!rst_n) row_t'(in_col_r) < size_r)
    else $error("input column beyond grid size");

  // the item that emits the final cell restarts both positions
  assert property (@(posedge clk) disable iff (!rst_n)
    step_last && !cfg_wr |=> (in_row_r == '0) && (in_col_r == '0) &&
                             (out_row_r == '0) && (out_col_r == '0))
    else $error("positions not cleared after end of grid");

  // a stalled result blocks new items
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r && !out_ready |-> !in_ready)
    else $error("item accepted while result is stalled");

  // the output row never runs ahead of the input row
  assert property (@(posedge clk) disable iff (!rst_n) out_row_r <= in_row_r)
    else $error("output row ahead of input row");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for diagonal_second_min_stencil, with a
// cycle-free predictor of the stencil pass, random idling and result checks
// depends on dsms_pkg and diagonal_second_min_stencil
`timescale 1ns / 100ps

module tb_top;
  import dsms_pkg::*;

  localparam int unsigned MIN_SIDE      = 3;
  localparam int unsigned ITEMS_TARGET  = 1870;
  localparam int unsigned CALM_TAIL     = 300;
  localparam int unsigned BIG_AT        = 700;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RUN_LIMIT_NS  = 6_000_000;
  localparam int unsigned DIR_ROWS      = 14;

  typedef struct packed {
    data_t value;
    logic  last;
  } cell_t;

  typedef struct packed {
    data_t smp;
    logic  fl;
    logic  chk;
    data_t ev;
    logic  el;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_grid_size;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] in_sample;
  logic              in_flush;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_value;
  logic              out_last;

  // predictor state: two previous rows by column, diagonal window, positions
  data_t       rows_mem [0:2*MAX_SIZE_DEF-1];
  data_t       two_up_prev;
  data_t       two_up_prev2;
  data_t       one_up_prev;
  data_t       in_prev;
  data_t       in_prev2;
  int unsigned in_pos;
  int unsigned out_pos;
  int unsigned side;

  cell_t       cells_due [$];
  cell_t       seen_want;
  dir_row_t    dir_tab [DIR_ROWS];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned gap_pct;
  int unsigned stall_left;
  bit          gaps_on;

  diagonal_second_min_stencil dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_grid_size (cfg_grid_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_flush      (in_flush),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_last      (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // second order statistic of the four diagonal neighbors
  function automatic data_t diag_second_low(input data_t a, input data_t b,
                                            input data_t c, input data_t d);
    data_t v [4];
    data_t t;
    int    i;
    int    j;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    for (i = 1; i < 4; i++) begin
      for (j = i; j > 0; j--) begin
        if (v[j-1] > v[j]) begin
          t      = v[j];
          v[j]   = v[j-1];
          v[j-1] = t;
        end
      end
    end
    return v[1];
  endfunction

  function automatic void stencil_clear();
    int i;
    for (i = 0; i < 2 * MAX_SIZE_DEF; i++) begin
      rows_mem[i] = '0;
    end
    two_up_prev  = '0;
    two_up_prev2 = '0;
    one_up_prev  = '0;
    in_prev      = '0;
    in_prev2     = '0;
    in_pos       = 0;
    out_pos      = 0;
    side         = (GRID_SIZE_RST > MAX_SIZE_DEF) ? MAX_SIZE_DEF : GRID_SIZE_RST;
  endfunction

  // size write clamps to the legal range and restarts the grid
  function automatic void stencil_resize(input logic [CFG_W-1:0] val);
    if (val < MIN_SIDE) begin
      side = MIN_SIDE;
    end else if (val > MAX_SIZE_DEF) begin
      side = MAX_SIZE_DEF;
    end else begin
      side = 32'(val);
    end
    in_pos  = 0;
    out_pos = 0;
  endfunction

  // one accepted item; returns 1 when it releases an updated cell
  function automatic bit stencil_advance(input data_t smp, input logic fl,
                                         output cell_t res);
    int unsigned cells;
    int unsigned col;
    int unsigned q;
    int unsigned row_q;
    int unsigned col_q;
    data_t       v;
    data_t       top_c;
    data_t       mid_c;
    data_t       val;
    logic [32:0] total;
    bit          got;
    got   = 1'b0;
    res   = '0;
    cells = side * side;
    // flush while samples are still due is dropped
    if (in_pos < cells) begin
      if (fl) begin
        return 1'b0;
      end
      v = smp;
    end else begin
      v = '0;
    end
    col   = in_pos % side;
    top_c = rows_mem[MAX_SIZE_DEF + col];
    mid_c = rows_mem[col];
    // emit the cell one row and one column behind
    if (in_pos >= side + 1) begin
      q     = out_pos;
      row_q = q / side;
      col_q = q % side;
      val   = one_up_prev;
      if (row_q != 0 && row_q != side - 1 && col_q != 0 && col_q != side - 1) begin
        total = {1'b0, val} + {1'b0, diag_second_low(two_up_prev2, top_c, in_prev2, v)};
        val   = total[32] ? '1 : total[31:0];
      end
      res.value = val;
      res.last  = (q == cells - 1);
      got       = 1'b1;
      out_pos   = q + 1;
    end
    // shift window and line memory
    two_up_prev2 = two_up_prev;
    two_up_prev  = top_c;
    one_up_prev  = mid_c;
    in_prev2     = in_prev;
    in_prev      = v;
    rows_mem[MAX_SIZE_DEF + col] = mid_c;
    rows_mem[col]                = v;
    if (got && res.last) begin
      in_pos  = 0;
      out_pos = 0;
    end else begin
      in_pos++;
    end
    return got;
  endfunction

  task automatic flag_mismatch(input string what, input data_t got, input data_t want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  function automatic data_t pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hF000_0000 | $urandom;
      2: return $urandom_range(0, 15);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // drive one item, optionally after an idle burst, and record its outcome
  task automatic push_item(input data_t smp, input logic fl, input logic chk,
                           input data_t ev, input logic el);
    int unsigned gap;
    cell_t       res;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    in_flush  <= fl;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    if (stencil_advance(smp, fl, res)) begin
      if (chk) begin
        res.value = ev;
        res.last  = el;
      end
      cells_due.push_back(res);
    end
  endtask

  // size write, only once every pending cell has come out
  task automatic write_side(input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_grid_size <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    stencil_resize(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // whole grids plus their flush tails; cut > 0 abandons the first grid early
  task automatic stream_grids(input int unsigned n_grids, input int unsigned cut);
    int unsigned g;
    int unsigned k;
    int unsigned cells;
    cells = side * side;
    for (g = 0; g < n_grids; g++) begin
      for (k = 0; k < cells; k++) begin
        if (cut != 0 && k == cut) begin
          return;
        end
        // stray flush while samples are due
        if ($urandom_range(0, 99) < 6) begin
          push_item($urandom, 1'b1, 1'b0, '0, 1'b0);
          items_sent++;
        end
        push_item(pick_sample(), 1'b0, 1'b0, '0, 1'b0);
        items_sent++;
      end
      // tail: flushes, and samples that only act as flushes
      for (k = 0; k <= side; k++) begin
        push_item($urandom, 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
        items_sent++;
      end
    end
  endtask

  // result side backpressure in bursts
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted cell with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        flag_mismatch("unexpected cell", out_value, '0);
      end else begin
        seen_want = cells_due.pop_front();
        if (out_value !== seen_want.value) begin
          flag_mismatch("out_value", out_value, seen_want.value);
        end
        if (out_last !== seen_want.last) begin
          flag_mismatch("out_last", data_t'(out_last), data_t'(seen_want.last));
        end
      end
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("diagonal_second_min_stencil test failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned r;
    int unsigned code;
    bit          big_done;
    in_valid      = 1'b0;
    in_sample     = '0;
    in_flush      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_grid_size = '0;
    rst_n         = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    gap_pct       = 20;
    gaps_on       = 1'b1;
    big_done      = 1'b0;
    stencil_clear();

    // 3x3 grid: three corners all ones, saturating center, stray flush,
    // sample in the tail, last on the final cell
    dir_tab[0]  = '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0};
    dir_tab[1]  = '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0};
    dir_tab[2]  = '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0};
    dir_tab[3]  = '{32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0000_0000, 1'b0};
    dir_tab[4]  = '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0};
    dir_tab[5]  = '{32'h0001_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0};
    dir_tab[6]  = '{32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 1'b0};
    dir_tab[7]  = '{32'h0000_0005, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0};
    dir_tab[8]  = '{32'hA5A5_A5A5, 1'b0, 1'b1, 32'h0000_0000, 1'b0};
    dir_tab[9]  = '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0};
    dir_tab[10] = '{32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b0};
    dir_tab[11] = '{32'hDEAD_BEEF, 1'b0, 1'b1, 32'h0000_0005, 1'b0};
    dir_tab[12] = '{32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5, 1'b0};
    dir_tab[13] = '{32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // size from reset: just enough samples to see the first border cells
    stream_grids(1, GRID_SIZE_RST + 4);

    // directed grid
    write_side(CFG_W'(MIN_SIDE));
    for (r = 0; r < DIR_ROWS; r++) begin
      push_item(dir_tab[r].smp, dir_tab[r].fl, dir_tab[r].chk, dir_tab[r].ev,
                dir_tab[r].el);
      items_sent++;
    end

    // random phases, mostly small grids
    while (items_sent < ITEMS_TARGET) begin
      if (items_sent >= ITEMS_TARGET - CALM_TAIL) begin
        gaps_on = 1'b0;
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (!big_done && items_sent >= BIG_AT) begin
        // all-ones size clamps to the maximum: reach the first interior row
        write_side({CFG_W{1'b1}});
        stream_grids(1, 2 * MAX_SIZE_DEF + 4);
        write_side(CFG_W'(MAX_SIZE_DEF));
        stream_grids(1, 40);
        big_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          code = $urandom_range(0, MIN_SIDE - 1);
        end else if (r < 20) begin
          code = $urandom_range(11, 24);
        end else begin
          code = $urandom_range(MIN_SIDE, 10);
        end
        write_side(CFG_W'(code));
        stream_grids($urandom_range(1, 3),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, side * side - 1) : 0);
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("diagonal_second_min_stencil test passed");
    end else begin
      $display("diagonal_second_min_stencil test failed");
    end
    $finish;
  end

endmodule

FILE: diagonal_second_min_stencil.f
hw/rtl/dsms_pkg.sv
hw/rtl/diagonal_second_min_stencil.sv
tb/tb_top.sv
